// ===== sv/u8xn_pkg.sv =====
package u8xn_pkg;

    localparam int CpWidth = 21;

    // result status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_BAD_LEAD = 3'd1;
    localparam logic [2:0] ST_BAD_CONT = 3'd2;
    localparam logic [2:0] ST_NUL      = 3'd3;
    localparam logic [2:0] ST_TRUNC    = 3'd4;

    // one step of the decoder, handed to the output register
    typedef struct packed {
        logic               emit;
        logic [CpWidth-1:0] code_point;
        logic [2:0]         seq_bytes;
        logic [2:0]         status;
        logic               name_start_ok;
        logic               name_char_ok;
    } u8xn_result_t;

endpackage

// ===== sv/u8xn_byte_if.sv =====
interface u8xn_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] byte_in;
    logic       buffer_end;

    modport source (output valid, output byte_in, output buffer_end, input ready);
    modport sink   (input valid, input byte_in, input buffer_end, output ready);
endinterface

// ===== sv/u8xn_result_if.sv =====
interface u8xn_result_if;
    logic        valid;
    logic        ready;
    logic [20:0] code_point;
    logic [2:0]  seq_bytes;
    logic [2:0]  status;
    logic        name_start_ok;
    logic        name_char_ok;

    modport source (output valid, output code_point, output seq_bytes, output status,
                    output name_start_ok, output name_char_ok, input ready);
    modport sink   (input valid, input code_point, input seq_bytes, input status,
                    input name_start_ok, input name_char_ok, output ready);
endinterface

// ===== sv/utf8_decode_xml_name_class.sv =====
// An accepted byte beat passes through the input register, then is decoded into
// the result register, which drives out_chan.
// One byte per cycle while results are taken; decoder state updates with each byte.
// Bytes that leave a sequence open produce no result beat.
// Reset (rst_n low, asynchronous) empties both registers and returns the decoder to idle.
module utf8_decode_xml_name_class
    import u8xn_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    u8xn_byte_if.sink     in_chan,
    u8xn_result_if.source out_chan
);

    logic         s1_valid;
    logic [7:0]   s1_byte;
    logic         s1_last;
    logic         advance;
    u8xn_result_t res;

    logic         out_valid_reg;
    logic         out_valid_next;
    u8xn_result_t out_reg;

    assign advance = s1_valid && (!out_valid_reg || out_chan.ready);

    u8xn_in_stage u_in_stage
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_chan (in_chan),
        .advance (advance),
        .valid   (s1_valid),
        .byte_q  (s1_byte),
        .last_q  (s1_last)
    );

    u8xn_decode u_decode
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .byte_q (s1_byte),
        .last_q (s1_last),
        .res    (res)
    );

    always_comb
    begin
        if (advance)
            out_valid_next = res.emit;
        else
            out_valid_next = out_valid_reg && !out_chan.ready;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.emit)
            out_reg <= res;
    end

    assign out_chan.valid         = out_valid_reg;
    assign out_chan.code_point    = out_reg.code_point;
    assign out_chan.seq_bytes     = out_reg.seq_bytes;
    assign out_chan.status        = out_reg.status;
    assign out_chan.name_start_ok = out_reg.name_start_ok;
    assign out_chan.name_char_ok  = out_reg.name_char_ok;

    a_stall_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid && out_valid_reg && !out_chan.ready |-> !in_chan.ready)
        else $error("input taken while the pipeline is stalled");

    a_error_fields_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status != ST_OK |->
            out_reg.code_point == '0 && out_reg.seq_bytes == 3'd0 &&
            !out_reg.name_start_ok && !out_reg.name_char_ok)
        else $error("error beat carries a code point");

endmodule

// ===== sv/u8xn_in_stage.sv =====
module u8xn_in_stage
(
    input  logic       clk,
    input  logic       rst_n,
    u8xn_byte_if.sink  in_chan,
    input  logic       advance,
    output logic       valid,
    output logic [7:0] byte_q,
    output logic       last_q
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;
    logic       take;

    assign in_chan.ready = !valid_reg || advance;
    assign take          = in_chan.valid && in_chan.ready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            byte_reg <= in_chan.byte_in;
            last_reg <= in_chan.buffer_end;
        end
    end

    assign valid  = valid_reg;
    assign byte_q = byte_reg;
    assign last_q = last_reg;

endmodule

// ===== sv/u8xn_classify.sv =====
module u8xn_classify
    import u8xn_pkg::*;
(
    input  logic [CpWidth-1:0] cp,
    output logic               start_ok,
    output logic               char_ok
);

    function automatic logic in_span(input logic [CpWidth-1:0] v,
                                     input logic [CpWidth-1:0] lo,
                                     input logic [CpWidth-1:0] hi);
        return (v >= lo) && (v <= hi);
    endfunction

    always_comb
    begin
        start_ok = (cp == 21'h3A) || in_span(cp, 21'h41, 21'h5A) || (cp == 21'h5F) ||
                   in_span(cp, 21'h61, 21'h7A) || in_span(cp, 21'hC0, 21'hD6) ||
                   in_span(cp, 21'hD8, 21'hF6) || in_span(cp, 21'hF8, 21'h2FF) ||
                   in_span(cp, 21'h370, 21'h37D) || in_span(cp, 21'h37F, 21'h1FFF) ||
                   in_span(cp, 21'h200C, 21'h200D) || in_span(cp, 21'h2070, 21'h218F) ||
                   in_span(cp, 21'h2C00, 21'h2FEF) || in_span(cp, 21'h3001, 21'hD7FF) ||
                   in_span(cp, 21'hF900, 21'hFDCF) || in_span(cp, 21'hFDF0, 21'hFFFD) ||
                   in_span(cp, 21'h10000, 21'hEFFFF);
        char_ok  = start_ok || (cp == 21'h2D) || (cp == 21'h2E) ||
                   in_span(cp, 21'h30, 21'h39) || (cp == 21'hB7) ||
                   in_span(cp, 21'h300, 21'h36F) || in_span(cp, 21'h203F, 21'h2040);
    end

endmodule

// ===== sv/u8xn_decode.sv =====
module u8xn_decode
    import u8xn_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  logic [7:0]   byte_q,
    input  logic         last_q,
    output u8xn_result_t res
);

    logic [1:0]         pending_reg;
    logic [1:0]         pending_next;
    logic [CpWidth-1:0] partial_reg;
    logic [CpWidth-1:0] partial_next;
    logic [2:0]         seq_len_reg;
    logic [2:0]         seq_len_next;

    logic [CpWidth-1:0] shifted;
    logic [1:0]         pending_dec;
    logic               emit;
    logic [2:0]         status;
    logic [CpWidth-1:0] cp;
    logic [2:0]         len;
    logic               ok;
    logic               start_ok;
    logic               char_ok;

    assign shifted     = {partial_reg[CpWidth-7:0], byte_q[5:0]};
    assign pending_dec = pending_reg - 2'd1;

    always_comb
    begin
        emit         = 1'b0;
        status       = ST_OK;
        cp           = '0;
        len          = 3'd0;
        pending_next = pending_reg;
        partial_next = partial_reg;
        seq_len_next = seq_len_reg;

        if (pending_reg == 2'd0)
        begin
            if (byte_q == 8'h00)
            begin
                emit   = 1'b1;
                status = ST_NUL;
            end
            else if (!byte_q[7])
            begin
                emit   = 1'b1;
                status = ST_OK;
                cp     = {13'd0, byte_q};
                len    = 3'd1;
            end
            else if (byte_q[7:5] == 3'b110 || byte_q[7:4] == 4'b1110 ||
                     byte_q[7:3] == 5'b11110)
            begin
                if (last_q)
                begin
                    emit   = 1'b1;
                    status = ST_TRUNC;
                end
                else if (byte_q[7:5] == 3'b110)
                begin
                    partial_next = {16'd0, byte_q[4:0]};
                    seq_len_next = 3'd2;
                    pending_next = 2'd1;
                end
                else if (byte_q[7:4] == 4'b1110)
                begin
                    partial_next = {17'd0, byte_q[3:0]};
                    seq_len_next = 3'd3;
                    pending_next = 2'd2;
                end
                else
                begin
                    partial_next = {18'd0, byte_q[2:0]};
                    seq_len_next = 3'd4;
                    pending_next = 2'd3;
                end
            end
            else
            begin
                emit   = 1'b1;
                status = ST_BAD_LEAD;
            end
        end
        else if (byte_q[7:6] != 2'b10)
        begin
            emit   = 1'b1;
            status = ST_BAD_CONT;
        end
        else if (pending_dec == 2'd0)
        begin
            emit   = 1'b1;
            status = ST_OK;
            cp     = shifted;
            len    = seq_len_reg;
        end
        else if (last_q)
        begin
            emit   = 1'b1;
            status = ST_TRUNC;
        end
        else
        begin
            partial_next = shifted;
            pending_next = pending_dec;
        end

        // every result leaves the decoder idle
        if (emit)
        begin
            pending_next = 2'd0;
            partial_next = '0;
            seq_len_next = 3'd0;
        end
    end

    assign ok = (status == ST_OK);

    u8xn_classify u_classify
    (
        .cp       (cp),
        .start_ok (start_ok),
        .char_ok  (char_ok)
    );

    always_comb
    begin
        res.emit          = emit;
        res.code_point    = cp;
        res.seq_bytes     = len;
        res.status        = status;
        res.name_start_ok = ok && start_ok;
        res.name_char_ok  = ok && char_ok;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= 2'd0;
            partial_reg <= '0;
            seq_len_reg <= 3'd0;
        end
        else if (fire)
        begin
            pending_reg <= pending_next;
            partial_reg <= partial_next;
            seq_len_reg <= seq_len_next;
        end
    end

    a_idle_after_emit : assert property (@(posedge clk) disable iff (!rst_n)
        fire && emit |=> pending_reg == 2'd0 && seq_len_reg == 3'd0)
        else $error("decoder not idle after a result");

    a_len_tracks_pending : assert property (@(posedge clk) disable iff (!rst_n)
        pending_reg != 2'd0 |-> seq_len_reg > {1'b0, pending_reg})
        else $error("sequence length does not cover pending bytes");

endmodule
